>>> hw/rtl/rd_pkg.sv
package rd_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int TEXT_W        = 64;
   localparam int SALARY_W      = 31;
   localparam int PHONE_W       = 34;

   typedef enum logic [2:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_LIST       = 3'd4
   } rd_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } rd_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_DATA
   } rd_state_type;

   typedef struct packed {
      logic [TEXT_W-1:0]   name_first;
      logic [TEXT_W-1:0]   name_second;
      logic [TEXT_W-1:0]   ssn;
      logic [TEXT_W-1:0]   dept;
      logic [TEXT_W-1:0]   role;
      logic [SALARY_W-1:0] salary;
      logic [PHONE_W-1:0]  phone;
   } rd_record_type;

   typedef struct packed {
      rd_status_type status;
      rd_record_type record;
      logic          last;
   } rd_result_type;

endpackage

>>> hw/rtl/record_deque.sv
// push: result word the cycle after acceptance; unused kinds: no word; next word accepted then
// pop: word passes the ring read register, then the output register; intake held meanwhile
// list of n entries: n words, one per cycle while not stalled; intake held to the last word
// empty or full cases answer without ring access; a stalled result holds intake until taken
// synchronous reset clears ring ends, entry count, sequencer and result valid
// ring contents are not cleared and need no clearing pass
module record_deque
   import rd_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int IdxW = $clog2(DEPTH),
   localparam int CntW = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_kind,
   input  logic [TEXT_W-1:0]   req_name_first,
   input  logic [TEXT_W-1:0]   req_name_second,
   input  logic [TEXT_W-1:0]   req_ssn_text,
   input  logic [TEXT_W-1:0]   req_dept_text,
   input  logic [TEXT_W-1:0]   req_role_text,
   input  logic [SALARY_W-1:0] req_salary,
   input  logic [PHONE_W-1:0]  req_phone,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [TEXT_W-1:0]   rsp_out_name_first,
   output logic [TEXT_W-1:0]   rsp_out_name_second,
   output logic [TEXT_W-1:0]   rsp_out_ssn,
   output logic [TEXT_W-1:0]   rsp_out_dept,
   output logic [TEXT_W-1:0]   rsp_out_role,
   output logic [SALARY_W-1:0] rsp_out_salary,
   output logic [PHONE_W-1:0]  rsp_out_phone,
   output logic [CntW-1:0]     rsp_occupancy,
   output logic                rsp_last
);

   rd_record_type   req_record;
   rd_result_type   result;
   logic [CntW-1:0] occupancy;
   logic            load;
   logic            slot_free;
   logic            wr_en, rd_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   rd_record_type   wr_data, rd_data;

   logic            rsp_valid_ff;
   rd_result_type   rsp_word_ff;
   logic [CntW-1:0] rsp_occ_ff;

   assign req_record.name_first  = req_name_first;
   assign req_record.name_second = req_name_second;
   assign req_record.ssn         = req_ssn_text;
   assign req_record.dept        = req_dept_text;
   assign req_record.role        = req_role_text;
   assign req_record.salary      = req_salary;
   assign req_record.phone       = req_phone;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   rd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_kind   (req_kind),
      .req_record (req_record),
      .req_stall  (req_stall),
      .slot_free  (slot_free),
      .load       (load),
      .result     (result),
      .occupancy  (occupancy),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   rd_ring_mem #(.DEPTH(DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_word_ff <= result;
         rsp_occ_ff  <= occupancy;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_word_ff.status;
   assign rsp_out_name_first  = rsp_word_ff.record.name_first;
   assign rsp_out_name_second = rsp_word_ff.record.name_second;
   assign rsp_out_ssn         = rsp_word_ff.record.ssn;
   assign rsp_out_dept        = rsp_word_ff.record.dept;
   assign rsp_out_role        = rsp_word_ff.record.role;
   assign rsp_out_salary      = rsp_word_ff.record.salary;
   assign rsp_out_phone       = rsp_word_ff.record.phone;
   assign rsp_occupancy       = rsp_occ_ff;
   assign rsp_last            = rsp_word_ff.last;

endmodule

>>> hw/rtl/rd_ring_mem.sv
module rd_ring_mem
   import rd_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int IdxW = $clog2(DEPTH)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IdxW-1:0] wr_addr,
   input  rd_record_type   wr_data,
   input  logic            rd_en,
   input  logic [IdxW-1:0] rd_addr,
   output rd_record_type   rd_data
);

   rd_record_type ring_ff [DEPTH];
   rd_record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/rd_ctrl.sv
module rd_ctrl
   import rd_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int IdxW = $clog2(DEPTH),
   localparam int CntW = $clog2(DEPTH + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [2:0]      req_kind,
   input  rd_record_type   req_record,
   output logic            req_stall,
   input  logic            slot_free,
   output logic            load,
   output rd_result_type   result,
   output logic [CntW-1:0] occupancy,
   output logic            wr_en,
   output logic [IdxW-1:0] wr_addr,
   output rd_record_type   wr_data,
   output logic            rd_en,
   output logic [IdxW-1:0] rd_addr,
   input  rd_record_type   rd_data
);

   localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   rd_state_type    state_ff, state_in;
   logic [IdxW-1:0] front_ff, front_in;
   logic [IdxW-1:0] back_ff, back_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] remain_ff, remain_in;
   logic [IdxW-1:0] scan_ff, scan_in;

   logic            accept;
   logic            is_full;
   logic            is_empty;
   rd_kind_type     kind;
   logic [IdxW-1:0] front_next, front_prev, back_next, back_prev, scan_next;

   function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] idx);
      return (idx == LastIdx) ? '0 : idx + IdxW'(1);
   endfunction

   function automatic logic [IdxW-1:0] ring_prev(input logic [IdxW-1:0] idx);
      return (idx == '0) ? LastIdx : idx - IdxW'(1);
   endfunction

   assign kind       = rd_kind_type'(req_kind);
   assign is_full    = (count_ff == FullCnt);
   assign is_empty   = (count_ff == '0);
   assign req_stall  = !((state_ff == ST_IDLE) && slot_free);
   assign accept     = req_valid && !req_stall;
   assign front_next = ring_next(front_ff);
   assign front_prev = ring_prev(front_ff);
   assign back_next  = ring_next(back_ff);
   assign back_prev  = ring_prev(back_ff);
   assign scan_next  = ring_next(scan_ff);

   // next state
   always_comb begin
      state_in  = state_ff;
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      remain_in = remain_ff;
      scan_in   = scan_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (kind)
                  KIND_PUSH_FRONT: begin
                     if (!is_full) begin
                        front_in = front_prev;
                        count_in = count_ff + CntW'(1);
                     end
                  end
                  KIND_PUSH_BACK: begin
                     if (!is_full) begin
                        back_in  = back_next;
                        count_in = count_ff + CntW'(1);
                     end
                  end
                  KIND_POP_FRONT: begin
                     if (!is_empty) begin
                        front_in  = front_next;
                        count_in  = count_ff - CntW'(1);
                        remain_in = CntW'(1);
                        state_in  = ST_DATA;
                     end
                  end
                  KIND_POP_BACK: begin
                     if (!is_empty) begin
                        back_in   = back_prev;
                        count_in  = count_ff - CntW'(1);
                        remain_in = CntW'(1);
                        state_in  = ST_DATA;
                     end
                  end
                  KIND_LIST: begin
                     if (!is_empty) begin
                        remain_in = count_ff;
                        scan_in   = front_next;
                        state_in  = ST_DATA;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DATA: begin
            if (slot_free) begin
               remain_in = remain_ff - CntW'(1);
               if (remain_ff == CntW'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  scan_in = scan_next;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      load      = 1'b0;
      result    = '0;
      occupancy = count_ff;
      wr_en     = 1'b0;
      wr_addr   = back_ff;
      wr_data   = req_record;
      rd_en     = 1'b0;
      rd_addr   = front_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               result.last = 1'b1;
               case (kind)
                  KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                     load = 1'b1;
                     if (is_full) begin
                        result.status = STATUS_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        wr_addr   = (kind == KIND_PUSH_FRONT) ? front_prev : back_ff;
                        occupancy = count_ff + CntW'(1);
                     end
                  end
                  KIND_POP_FRONT, KIND_POP_BACK, KIND_LIST: begin
                     if (is_empty) begin
                        load          = 1'b1;
                        result.status = STATUS_EMPTY;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = (kind == KIND_POP_BACK) ? back_prev : front_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DATA: begin
            if (slot_free) begin
               load          = 1'b1;
               result.record = rd_data;
               result.last   = (remain_ff == CntW'(1));
               if (remain_ff != CntW'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = scan_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         front_ff  <= '0;
         back_ff   <= '0;
         count_ff  <= '0;
         remain_ff <= '0;
         scan_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         back_ff   <= back_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         scan_ff   <= scan_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("entry count above depth");

   a_empty_aligned: assert property (@(posedge clock) disable iff (reset)
      is_empty |-> front_ff == back_ff)
      else $error("empty ring with misaligned ends");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("ring written and read in one cycle");

   a_data_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DATA |-> remain_ff != '0)
      else $error("read stage with nothing left to deliver");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> slot_free)
      else $error("result loaded into a busy output slot");

endmodule
